[sv/dsw_pkg.sv]
// Shared constants, types and the segment table of the decimal frame writer.
`default_nettype none

package dsw_pkg;

  // Command and address bytes of the display bus.
  localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h8F;
  localparam logic [7:0] ADDR_BASE      = 8'hC0;

  // Conversion geometry: eight BCD digits, four input bits per stage.
  localparam int NUMBER_WIDTH = 32;
  localparam int BCD_DIGITS   = 8;
  localparam int BCD_WIDTH    = 4 * BCD_DIGITS;
  localparam int STAGE_BITS   = 4;
  localparam int STAGE_COUNT  = NUMBER_WIDTH / STAGE_BITS;

  // Payload carried through the binary to BCD stages.
  typedef struct packed {
    logic                    clear;
    logic [NUMBER_WIDTH-1:0] rest;
    logic [BCD_WIDTH-1:0]    bcd;
  } dsw_dabble_t;

  // Seven-segment code of one BCD digit, bit order -PGFEDCBA.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[sv/dsw_dabble_stage.sv]
// One registered shift-and-add-three stage of the binary to BCD conversion.
`default_nettype none

module dsw_dabble_stage import dsw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  dsw_dabble_t data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output dsw_dabble_t data_o
);

  logic        valid_q;
  dsw_dabble_t data_q;
  dsw_dabble_t data_d;

  // The stage takes a beat when it is empty or its beat moves on.
  assign ready_o = !valid_q || ready_i;

  // Shift in STAGE_BITS input bits; digits of five or more get three added first.
  // Carries out of the top digit are dropped, which keeps the value modulo 10^8.
  always_comb begin
    logic [BCD_WIDTH-1:0]    b;
    logic [NUMBER_WIDTH-1:0] r;
    b = data_i.bcd;
    r = data_i.rest;
    for (int s = 0; s < STAGE_BITS; s++) begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
        if (b[4*k +: 4] >= 4'd5) begin
          b[4*k +: 4] = b[4*k +: 4] + 4'd3;
        end
      end
      {b, r} = {b[BCD_WIDTH-2:0], r, 1'b0};
    end
    data_d.clear = data_i.clear;
    data_d.rest  = r;
    data_d.bcd   = b;
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[sv/dsw_seg_stage.sv]
// Registered stage that turns the kept BCD digits into segment codes.
`default_nettype none

module dsw_seg_stage import dsw_pkg::*; #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  dsw_dabble_t                 data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [DIGIT_COUNT-1:0][7:0] codes_o
);

  logic                        valid_q;
  logic [DIGIT_COUNT-1:0][7:0] codes_q;
  logic [DIGIT_COUNT-1:0][7:0] codes_d;

  assign ready_o = !valid_q || ready_i;

  // Code k belongs to the most significant kept digit first; clear blanks all.
  always_comb begin
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      codes_d[k] = data_i.clear ? 8'h00 : seg_code(data_i.bcd[4*(DIGIT_COUNT-1-k) +: 4]);
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Segment codes.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      codes_q <= codes_d;
    end
  end

  assign valid_o = valid_q;
  assign codes_o = codes_q;

endmodule

`default_nettype wire

[sv/dsw_serializer.sv]
// Byte sequencer that sends the command, address and data frames of one request.
`default_nettype none

module dsw_serializer import dsw_pkg::*; #(
  parameter int DIGIT_COUNT    = 8,
  parameter int POSITION_COUNT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [DIGIT_COUNT-1:0][7:0] codes_i,
  output logic                        strobe_o,
  output logic [7:0]                  bus_byte_o,
  output logic                        frame_start_o,
  output logic                        frame_end_o,
  output logic                        last_o
);

  localparam int LastIdx = 2 * POSITION_COUNT + 1;
  localparam int CntW    = $clog2(LastIdx + 1);

  logic                        active_q;
  logic [CntW-1:0]             cnt_q;
  logic [DIGIT_COUNT-1:0][7:0] codes_q;
  logic                        at_last;
  logic                        take;
  logic [CntW-1:0]             j;
  logic [7:0]                  byte_d;
  logic                        fs_d;
  logic                        fe_d;
  logic                        last_d;
  logic                        strobe_q;
  logic [7:0]                  byte_q;
  logic                        fs_q;
  logic                        fe_q;
  logic                        last_q;

  // A new request loads as the last beat of the current one goes out.
  assign at_last = (cnt_q == CntW'(LastIdx));
  assign ready_o = !active_q || at_last;
  assign take    = valid_i && ready_o;

  // Sequence counter and held segment codes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (take) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else if (active_q) begin
      if (at_last) begin
        active_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      codes_q <= codes_i;
    end
  end

  // Beat decode: command, then address and data pairs, then display on.
  assign j = cnt_q - 1'b1;

  always_comb begin
    byte_d = 8'h00;
    fs_d   = 1'b0;
    fe_d   = 1'b0;
    last_d = 1'b0;
    if (cnt_q == '0) begin
      byte_d = CMD_FIXED_ADDR;
      fs_d   = 1'b1;
      fe_d   = 1'b1;
    end else if (at_last) begin
      byte_d = CMD_DISPLAY_ON;
      fs_d   = 1'b1;
      fe_d   = 1'b1;
      last_d = 1'b1;
    end else if (!j[0]) begin
      byte_d = ADDR_BASE + 8'(j >> 1);
      fs_d   = 1'b1;
    end else begin
      fe_d = 1'b1;
      // Data of even position 2k is digit k; every other position gets zero.
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        if (2 * k < POSITION_COUNT && j == CntW'(4 * k + 1)) begin
          byte_d = codes_q[k];
        end
      end
    end
  end

  // Output register: each beat is shown for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    fs_q   <= fs_d;
    fe_q   <= fe_d;
    last_q <= last_d;
  end

  assign strobe_o      = strobe_q;
  assign bus_byte_o    = byte_q;
  assign frame_start_o = fs_q;
  assign frame_end_o   = fe_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

[sv/decimal_seven_segment_frame_writer.sv]
// Top level of the decimal seven-segment frame writer.
//
// A request is taken on a rising edge with start high and busy low. func_i
// selects show-number (0) or clear (1); number_i is the value, of which the
// low DIGIT_COUNT decimal digits are shown with leading zeros.
// Each request gives 2*POSITION_COUNT+2 beats on the output, one per cycle,
// each marked by strobe_o for exactly one cycle: the fixed-address command,
// an address and a data beat for every position, then the display-on command.
// frame_start_o and frame_end_o mark chip-select framing, last_o the final beat.
// On the way to the first beat a request passes eight conversion stages of four
// input bits each, one segment stage, the sequencer load and the output register.
// The byte sequencer sends one beat a cycle, so requests stream without gaps;
// up to nine more requests wait in the stages meanwhile, and busy is high only
// while the first stage is full and cannot move on.
// The receiver cannot stall; beats are never held back or repeated.
// Reset empties all stages and the sequencer; no beat is shown afterward
// until a new request arrives.
`default_nettype none

module decimal_seven_segment_frame_writer import dsw_pkg::*; #(
  parameter int DIGIT_COUNT    = 8,
  parameter int POSITION_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [31:0] number_i,
  output logic        strobe_o,
  output logic [7:0]  bus_byte_o,
  output logic        frame_start_o,
  output logic        frame_end_o,
  output logic        last_o
);

  dsw_dabble_t                 pipe_data  [STAGE_COUNT+1];
  logic                        pipe_valid [STAGE_COUNT+1];
  logic                        pipe_ready [STAGE_COUNT+1];
  logic                        seg_valid;
  logic                        seg_ready;
  logic [DIGIT_COUNT-1:0][7:0] seg_codes;

  // Entry of the conversion pipeline.
  assign pipe_valid[0]       = start;
  assign pipe_data[0].clear  = func_i;
  assign pipe_data[0].rest   = number_i;
  assign pipe_data[0].bcd    = '0;
  assign busy                = !pipe_ready[0];

  // Binary to BCD conversion, four input bits per stage.
  for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_dabble
    dsw_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pipe_valid[g]),
      .ready_o (pipe_ready[g]),
      .data_i  (pipe_data[g]),
      .valid_o (pipe_valid[g+1]),
      .ready_i (pipe_ready[g+1]),
      .data_o  (pipe_data[g+1])
    );
  end

  // Segment encoding.
  dsw_seg_stage #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pipe_valid[STAGE_COUNT]),
    .ready_o (pipe_ready[STAGE_COUNT]),
    .data_i  (pipe_data[STAGE_COUNT]),
    .valid_o (seg_valid),
    .ready_i (seg_ready),
    .codes_o (seg_codes)
  );

  // Frame sequencing and output register.
  dsw_serializer #(
    .DIGIT_COUNT    (DIGIT_COUNT),
    .POSITION_COUNT (POSITION_COUNT)
  ) u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (seg_valid),
    .ready_o       (seg_ready),
    .codes_i       (seg_codes),
    .strobe_o      (strobe_o),
    .bus_byte_o    (bus_byte_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  // The final beat is always a one-byte command frame.
  a_last_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> frame_start_o && frame_end_o)
    else $error("last beat is not a one-byte frame");

  // An address beat that opens a two-byte frame is followed by its data beat.
  a_addr_then_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && frame_start_o && !frame_end_o |=>
      strobe_o && !frame_start_o && frame_end_o && !last_o)
    else $error("address beat not followed by data beat");

  // A data beat only ever follows an address beat.
  a_data_after_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !frame_start_o |->
      $past(strobe_o) && $past(frame_start_o) && !$past(frame_end_o))
    else $error("data beat without preceding address beat");
`endif

endmodule

`default_nettype wire
